// ===== hdl/sdld_pkg.sv =====
// shared constants, types and helpers of the scan data line decoder
`default_nettype none
package sdld_pkg;

    localparam int LINE_CHARS = 72;
    localparam int POS_W      = $clog2(LINE_CHARS);
    localparam int LEN_W      = $clog2(LINE_CHARS + 1);
    localparam int EXT_W      = POS_W + 2;
    localparam int CNT_W      = 12;
    localparam int TIME_W     = 24;
    localparam int WRAP_W     = 16;
    localparam int VAL_W      = 18;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] CHAR_BIAS = 8'h30;
    localparam logic [CNT_W-1:0] MAX_READINGS_RESET = 12'd2048;
    localparam logic [2:0] GROUP_SHORT = 3'd3;
    localparam logic [2:0] GROUP_LONG  = 3'd6;
    localparam logic [1:0] REPEAT_SAT  = 2'd3;
    localparam logic [1:0] REPEAT_LIMIT = 2'd2;
    localparam logic [LEN_W-1:0] TS_CHARS = LEN_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_READINGS   = 1'b1;

    typedef enum logic [1:0] {
        KIND_TIME    = 2'd0,
        KIND_READING = 2'd1,
        KIND_END     = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_TIME_CHK = 3'd0,
        ERR_DATA_CHK = 3'd1,
        ERR_TOO_MANY = 3'd2,
        ERR_REPEAT   = 3'd3,
        ERR_TOO_LONG = 3'd4
    } t_err;

    typedef struct packed {
        logic  in_await;
        logic  disc;
        logic  store;
        logic  overflow;
        logic  line_clear;
        logic  zero_carry;
        logic  grp_setup;
        logic  rep_upd;
        logic  time_commit;
        logic  grp_start;
        logic  rd_grp;
        logic  grp_next;
        logic  mv_setup;
        logic  mv_rd;
        logic  mv_wr;
        logic  emit;
        t_kind kind;
        t_err  err;
    } t_dp_cmd;

    typedef struct packed {
        logic lf;
        logic len_zero;
        logic overflow;
        logic ts_ok;
        logic data_ok;
        logic rep_fail;
        logic grp_more;
        logic limit;
        logic k_last;
        logic mv_more;
        logic out_free;
    } t_dp_status;

    function automatic logic [5:0] char_val(input logic [7:0] b);
        char_val = b[5:0] - CHAR_BIAS[5:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sdld_if.sv =====
// byte and result channel interfaces
`default_nettype none
interface sdld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sdld_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [17:0] range_mm;
    logic [17:0] intensity;
    logic [39:0] time_ms;
    logic [2:0]  error_code;
    logic        last;
    modport source (output valid, output result_kind, output range_mm, output intensity,
                    output time_ms, output error_code, output last, input ready);
    modport sink   (input valid, input result_kind, input range_mm, input intensity,
                    input time_ms, input error_code, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/sdld_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module sdld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 72
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/sdld_ctrl.sv =====
// sequencer: line phase and per-line decode steps
`default_nettype none
module sdld_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sdld_pkg::t_dp_status i_st,
    output sdld_pkg::t_dp_cmd        o_cmd
);
    typedef enum logic [1:0] {PH_AWAIT, PH_DATA, PH_DISCARD} t_phase;
    typedef enum logic [3:0] {
        S_IDLE, S_TIME, S_END, S_FAIL, S_GCHK, S_GRD, S_GLAST, S_GOUT, S_MCHK, S_MWR
    } t_state;

    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    sdld_pkg::t_err r_err, n_err;
    logic           take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_err   = r_err;
        o_cmd   = '0;
        o_cmd.kind = sdld_pkg::KIND_ERROR;
        o_cmd.err  = r_err;
        o_cmd.in_await = (r_phase == PH_AWAIT);
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (r_phase == PH_DISCARD) begin
                        o_cmd.disc = 1'b1;
                        if (i_st.lf && i_st.len_zero) begin
                            n_phase = PH_AWAIT;
                        end
                    end else begin
                        o_cmd.zero_carry = (r_phase == PH_AWAIT);
                        if (!i_st.lf) begin
                            if (i_st.overflow) begin
                                o_cmd.overflow = 1'b1;
                                n_err   = sdld_pkg::ERR_TOO_LONG;
                                n_state = S_FAIL;
                            end else begin
                                o_cmd.store = 1'b1;
                            end
                        end else begin
                            o_cmd.line_clear = 1'b1;
                            if (r_phase == PH_AWAIT) begin
                                if (!i_st.len_zero) begin
                                    if (i_st.ts_ok) begin
                                        n_state = S_TIME;
                                    end else begin
                                        n_err   = sdld_pkg::ERR_TIME_CHK;
                                        n_state = S_FAIL;
                                    end
                                end
                            end else if (i_st.len_zero) begin
                                n_state = S_END;
                            end else if (i_st.data_ok) begin
                                o_cmd.grp_setup = 1'b1;
                                n_state = S_GCHK;
                            end else begin
                                n_err   = sdld_pkg::ERR_DATA_CHK;
                                n_state = S_FAIL;
                            end
                        end
                    end
                end
            end
            S_TIME: begin
                if (i_st.out_free) begin
                    o_cmd.rep_upd = 1'b1;
                    o_cmd.emit    = 1'b1;
                    n_state = S_IDLE;
                    if (i_st.rep_fail) begin
                        o_cmd.err = sdld_pkg::ERR_REPEAT;
                        n_phase = PH_DISCARD;
                    end else begin
                        o_cmd.kind        = sdld_pkg::KIND_TIME;
                        o_cmd.time_commit = 1'b1;
                        n_phase = PH_DATA;
                    end
                end
            end
            S_END: begin
                if (i_st.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.kind       = sdld_pkg::KIND_END;
                    o_cmd.zero_carry = 1'b1;
                    n_phase = PH_AWAIT;
                    n_state = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_phase = PH_DISCARD;
                    n_state = S_IDLE;
                end
            end
            S_GCHK: begin
                if (!i_st.grp_more) begin
                    o_cmd.mv_setup = 1'b1;
                    n_state = S_MCHK;
                end else if (i_st.limit) begin
                    n_err   = sdld_pkg::ERR_TOO_MANY;
                    n_state = S_FAIL;
                end else begin
                    o_cmd.grp_start = 1'b1;
                    n_state = S_GRD;
                end
            end
            S_GRD: begin
                o_cmd.rd_grp = 1'b1;
                if (i_st.k_last) begin
                    n_state = S_GLAST;
                end
            end
            S_GLAST: n_state = S_GOUT;
            S_GOUT: begin
                if (i_st.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = sdld_pkg::KIND_READING;
                    o_cmd.grp_next = 1'b1;
                    n_state = S_GCHK;
                end
            end
            S_MCHK: begin
                if (i_st.mv_more) begin
                    o_cmd.mv_rd = 1'b1;
                    n_state = S_MWR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MWR: begin
                o_cmd.mv_wr = 1'b1;
                n_state = S_MCHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_AWAIT;
            r_err   <= sdld_pkg::ERR_TIME_CHK;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_err   <= n_err;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/sdld_dp.sv =====
// datapath: line store, checksums, time tracking, group decode, result register
`default_nettype none
module sdld_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [sdld_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sdld_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic [7:0]                   i_rx_byte,
    input  wire sdld_pkg::t_dp_cmd            i_cmd,
    output sdld_pkg::t_dp_status              o_st,
    sdld_result_if.source                     o_res
);
    localparam int POS_W = sdld_pkg::POS_W;
    localparam int LEN_W = sdld_pkg::LEN_W;
    localparam int EXT_W = sdld_pkg::EXT_W;

    logic                        r_imode;
    logic [sdld_pkg::CNT_W-1:0]  r_max;
    logic [LEN_W-1:0]            r_len;
    logic [2:0]                  r_carry;
    logic [5:0]                  r_sum;
    logic [7:0]                  r_lastb;
    logic [5:0]                  r_ts_sum;
    logic [7:0]                  r_ts_chk;
    logic [sdld_pkg::TIME_W-1:0] r_t;
    logic [sdld_pkg::TIME_W-1:0] r_prev;
    logic [sdld_pkg::WRAP_W-1:0] r_wrap;
    logic [1:0]                  r_rep;
    logic [sdld_pkg::CNT_W-1:0]  r_rcount;
    logic [POS_W-1:0]            r_total;
    logic [POS_W-1:0]            r_pos;
    logic [2:0]                  r_k;
    logic                        r_rdv;
    logic [35:0]                 r_acc;

    logic                        r_ovalid;
    logic [1:0]                  r_okind;
    logic [17:0]                 r_orange;
    logic [17:0]                 r_ointen;
    logic [39:0]                 r_otime;
    logic [2:0]                  r_oerr;
    logic                        r_olast;

    logic [2:0]                  size;
    logic [2:0]                  eff_carry;
    logic [LEN_W:0]              fill;
    logic [POS_W-1:0]            waddr;
    logic [5:0]                  cv;
    logic [5:0]                  sum_excl;
    logic [7:0]                  data_chk;
    logic [7:0]                  ts_want;
    logic [EXT_W-1:0]            pos_ext, total_ext, size_ext;
    logic                        t_eq;
    logic [sdld_pkg::WRAP_W-1:0] wrap_n;
    logic                        ram_we;
    logic [POS_W-1:0]            ram_waddr;
    logic [7:0]                  ram_wdata;
    logic                        ram_re;
    logic [POS_W-1:0]            ram_raddr;
    logic [7:0]                  ram_rdata;
    logic                        rd_last;

    assign size      = r_imode ? sdld_pkg::GROUP_LONG : sdld_pkg::GROUP_SHORT;
    assign eff_carry = i_cmd.in_await ? 3'd0 : r_carry;
    assign fill      = (LEN_W+1)'(eff_carry) + (LEN_W+1)'(r_len);
    assign waddr     = POS_W'(fill);
    assign cv        = sdld_pkg::char_val(i_rx_byte);
    assign sum_excl  = r_sum - r_lastb[5:0];
    assign data_chk  = {2'b00, sum_excl} + sdld_pkg::CHAR_BIAS;
    assign ts_want   = {2'b00, r_ts_sum} + sdld_pkg::CHAR_BIAS;
    assign pos_ext   = EXT_W'(r_pos);
    assign total_ext = EXT_W'(r_total);
    assign size_ext  = EXT_W'(size);
    assign t_eq      = (r_t == r_prev);
    assign wrap_n    = (r_t < r_prev) ? r_wrap + 1'b1 : r_wrap;
    assign rd_last   = (pos_ext + size_ext + size_ext) > total_ext;

    always_comb begin
        o_st.lf       = (i_rx_byte == sdld_pkg::BYTE_LF);
        o_st.len_zero = (r_len == '0);
        o_st.overflow = fill >= (LEN_W+1)'(sdld_pkg::LINE_CHARS);
        o_st.ts_ok    = (r_len >= sdld_pkg::TS_CHARS) && (r_ts_chk == ts_want);
        o_st.data_ok  = (r_lastb == data_chk);
        o_st.rep_fail = t_eq && (r_rep >= sdld_pkg::REPEAT_LIMIT);
        o_st.grp_more = (pos_ext + size_ext) <= total_ext;
        o_st.limit    = (r_rcount >= r_max);
        o_st.k_last   = (r_k == size - 3'd1);
        o_st.mv_more  = (r_k < r_carry);
        o_st.out_free = !r_ovalid || o_res.ready;
    end

    // one port writes bytes or moved carry chars, the other reads groups or carry chars
    assign ram_we    = i_cmd.store || i_cmd.mv_wr;
    assign ram_waddr = i_cmd.mv_wr ? POS_W'(r_k) : waddr;
    assign ram_wdata = i_cmd.mv_wr ? ram_rdata : i_rx_byte;
    assign ram_re    = i_cmd.rd_grp || i_cmd.mv_rd;
    assign ram_raddr = r_pos + POS_W'(r_k);

    sdld_ram #(.WIDTH(8), .DEPTH(sdld_pkg::LINE_CHARS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imode  <= 1'b0;
            r_max    <= sdld_pkg::MAX_READINGS_RESET;
            r_len    <= '0;
            r_carry  <= '0;
            r_sum    <= '0;
            r_prev   <= '0;
            r_wrap   <= '0;
            r_rep    <= '0;
            r_rcount <= '0;
            r_rdv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == sdld_pkg::CFG_INTENSITY_MODE) begin
                    r_imode <= i_cfg_data[0];
                end else begin
                    r_max <= i_cfg_data;
                end
            end
            if (i_cmd.zero_carry) begin
                r_carry <= '0;
            end
            if (i_cmd.disc) begin
                r_len <= (i_rx_byte == sdld_pkg::BYTE_LF) ? '0 : LEN_W'(1);
                r_sum <= '0;
            end
            if (i_cmd.overflow) begin
                r_len <= LEN_W'(1);
            end
            if (i_cmd.store) begin
                r_len   <= r_len + 1'b1;
                r_sum   <= r_sum + i_rx_byte[5:0];
                r_lastb <= i_rx_byte;
                case (r_len)
                    LEN_W'(0): begin
                        r_t[23:18] <= cv;
                        r_ts_sum   <= i_rx_byte[5:0];
                    end
                    LEN_W'(1): begin
                        r_t[17:12] <= cv;
                        r_ts_sum   <= r_ts_sum + i_rx_byte[5:0];
                    end
                    LEN_W'(2): begin
                        r_t[11:6] <= cv;
                        r_ts_sum  <= r_ts_sum + i_rx_byte[5:0];
                    end
                    LEN_W'(3): begin
                        r_t[5:0] <= cv;
                        r_ts_sum <= r_ts_sum + i_rx_byte[5:0];
                    end
                    LEN_W'(4): r_ts_chk <= i_rx_byte;
                    default: ;
                endcase
            end
            if (i_cmd.line_clear) begin
                r_len <= '0;
                r_sum <= '0;
            end
            if (i_cmd.grp_setup) begin
                // characters ahead of the checksum char, carry included
                r_total <= POS_W'(fill - (LEN_W+1)'(1));
                r_pos   <= '0;
            end
            if (i_cmd.rep_upd) begin
                if (!t_eq) begin
                    r_rep <= '0;
                end else if (r_rep != sdld_pkg::REPEAT_SAT) begin
                    r_rep <= r_rep + 1'b1;
                end
            end
            if (i_cmd.time_commit) begin
                r_wrap   <= wrap_n;
                r_prev   <= r_t;
                r_rcount <= '0;
                r_carry  <= '0;
            end
            if (i_cmd.grp_start) begin
                r_k <= '0;
            end
            if (i_cmd.rd_grp || i_cmd.mv_wr) begin
                r_k <= r_k + 1'b1;
            end
            r_rdv <= i_cmd.rd_grp;
            if (r_rdv) begin
                r_acc <= {r_acc[29:0], sdld_pkg::char_val(ram_rdata)};
            end
            if (i_cmd.grp_next) begin
                r_pos    <= r_pos + POS_W'(size);
                r_rcount <= r_rcount + 1'b1;
            end
            if (i_cmd.mv_setup) begin
                r_carry <= 3'(r_total - r_pos);
                r_k     <= '0;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_okind  <= i_cmd.kind;
            r_orange <= (i_cmd.kind == sdld_pkg::KIND_READING) ?
                        (r_imode ? r_acc[35:18] : r_acc[17:0]) : '0;
            r_ointen <= ((i_cmd.kind == sdld_pkg::KIND_READING) && r_imode) ?
                        r_acc[17:0] : '0;
            r_otime  <= (i_cmd.kind == sdld_pkg::KIND_TIME) ? {wrap_n, r_t} : '0;
            r_oerr   <= (i_cmd.kind == sdld_pkg::KIND_ERROR) ? i_cmd.err : '0;
            r_olast  <= (i_cmd.kind == sdld_pkg::KIND_READING) ? rd_last : 1'b1;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.result_kind = r_okind;
    assign o_res.range_mm    = r_orange;
    assign o_res.intensity   = r_ointen;
    assign o_res.time_ms     = r_otime;
    assign o_res.error_code  = r_oerr;
    assign o_res.last        = r_olast;
endmodule
`default_nettype wire

// ===== hdl/scan_data_line_decoder.sv =====
// top level of the scan reply line decoder
//
// i_byte carries received characters of a scan reply, one per transfer; 0x0A
// ends a line. o_result carries decoded items: a timestamp after the first
// line, readings after each data line, a scan end after an empty line, and
// errors, with last marking the final result caused by one byte.
// A character that ends no line leaves i_byte.ready high, unless it
// overflows the line store. A data line end sets off a decode sequence:
// groups of 3 or 6 chars read one a cycle from the single line store read
// port, then each carried character moved to the front; i_byte.ready stays
// low meanwhile. Results pass through one output register, so a byte can
// be taken while the last result still waits; when the receiver stalls,
// the sequencer holds at its next result until the register frees up.
// Configuration (i_cfg_*) must be written while the block is idle, which is
// not enforced here: index 0 is intensity mode, index 1 the readings limit
// per scan. Reset (synchronous, active low) returns to waiting for a
// timestamp line, clears the time history and the output register; the
// line store needs no clearing since only written entries are read.
`default_nettype none
module scan_data_line_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sdld_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sdld_pkg::CFG_W-1:0]     i_cfg_data,
    sdld_byte_if.sink                           i_byte,
    sdld_result_if.source                       o_result
);
    sdld_pkg::t_dp_cmd    cmd;
    sdld_pkg::t_dp_status st;

    sdld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte.valid),
        .o_in_ready (i_byte.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    sdld_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_byte  (i_byte.rx_byte),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_res      (o_result)
    );

    a_err_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.result_kind != sdld_pkg::KIND_ERROR)
            |-> (o_result.error_code == '0))
        else $error("error code on a non-error result");

    a_time_only_on_timestamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.result_kind != sdld_pkg::KIND_TIME)
            |-> (o_result.time_ms == '0))
        else $error("time on a non-timestamp result");

    a_non_reading_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.result_kind != sdld_pkg::KIND_READING)
            |-> (o_result.range_mm == '0) && (o_result.intensity == '0) && o_result.last)
        else $error("non-reading result with range data or not last");

    a_no_byte_while_decoding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_grp || cmd.mv_rd || cmd.mv_wr |-> !i_byte.ready)
        else $error("byte port open during line decode");
endmodule
`default_nettype wire

// ===== test/scan_data_line_decoder_tb.sv =====
// testbench of the scan reply line decoder: directed and random scan replies
`default_nettype none
module scan_data_line_decoder_tb;
    import sdld_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind       kind;
        logic [17:0] range_mm;
        logic [17:0] intensity;
        logic [39:0] time_ms;
        t_err        err;
        logic        last;
    } t_result;

    typedef enum logic [1:0] {
        ST_AWAIT   = 2'd0,
        ST_DATA    = 2'd1,
        ST_DISCARD = 2'd2
    } t_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    sdld_byte_if   byte_ch ();
    sdld_result_if res_ch ();

    scan_data_line_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_byte     (byte_ch.sink),
        .o_result   (res_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // decoder state mirror
    logic        mode_six;
    logic [11:0] limit_rd;
    t_state      st;
    logic [7:0]  store [LINE_CHARS];
    int unsigned len_cur, carry_n, rd_count, prev_t, wraps, reps;

    t_result expected_q[$];
    int errors = 0;
    int n_results = 0;
    int n_bytes = 0;
    bit idle_en = 1'b1;
    bit rx_hold = 1'b0;
    int n_readings = 0, n_timestamps = 0, n_errors_seen = 0;

    function automatic logic [5:0] cval(logic [7:0] b);
        return 6'(b - 8'h30);
    endfunction

    function automatic logic [17:0] group_at(int unsigned p);
        return {cval(store[p % LINE_CHARS]), cval(store[(p + 1) % LINE_CHARS]),
                cval(store[(p + 2) % LINE_CHARS])};
    endfunction

    function automatic void push_result(t_kind k, logic [17:0] r, logic [17:0] it,
                                        logic [39:0] tm, t_err e);
        t_result x;
        x.kind = k; x.range_mm = r; x.intensity = it; x.time_ms = tm;
        x.err = e; x.last = 1'b0;
        expected_q = {expected_q, x};
    endfunction

    function automatic void push_error(t_err e);
        push_result(KIND_ERROR, '0, '0, '0, e);
        st = ST_DISCARD;
    endfunction

    function automatic void decode_time();
        int unsigned s, t;
        s = 0;
        if (len_cur < 5) begin
            push_error(ERR_TIME_CHK);
            return;
        end
        for (int i = 0; i < 4; i++) s += store[i];
        if (store[4] != (s & 63) + 8'h30) begin
            push_error(ERR_TIME_CHK);
            return;
        end
        t = {cval(store[0]), cval(store[1]), cval(store[2]), cval(store[3])};
        if (t == prev_t) begin
            if (reps < 3) reps++;
            if (reps > 2) begin
                push_error(ERR_REPEAT);
                return;
            end
        end else begin
            reps = 0;
        end
        if (t < prev_t) wraps = (wraps + 1) & 16'hFFFF;
        prev_t = t;
        push_result(KIND_TIME, '0, '0, {wraps[15:0], t[23:0]}, ERR_TIME_CHK);
        st = ST_DATA;
        carry_n = 0;
        rd_count = 0;
    endfunction

    function automatic void decode_data();
        int unsigned s, total, gsize, used;
        s = 0;
        if (len_cur == 0) begin
            push_result(KIND_END, '0, '0, '0, ERR_TIME_CHK);
            st = ST_AWAIT;
            carry_n = 0;
            return;
        end
        for (int i = 0; i + 1 < len_cur; i++) s += store[(carry_n + i) % LINE_CHARS];
        if (store[(carry_n + len_cur - 1) % LINE_CHARS] != (s & 63) + 8'h30) begin
            push_error(ERR_DATA_CHK);
            return;
        end
        gsize = mode_six ? 6 : 3;
        total = carry_n + len_cur - 1;
        used = total - (total % gsize);
        for (int p = 0; p < used; p += gsize) begin
            if (rd_count >= limit_rd) begin
                push_error(ERR_TOO_MANY);
                return;
            end
            push_result(KIND_READING, group_at(p), mode_six ? group_at(p + 3) : 18'd0,
                        '0, ERR_TIME_CHK);
            rd_count = (rd_count + 1) & 12'hFFF;
        end
        carry_n = total - used;
        for (int i = 0; i < carry_n; i++) store[i] = store[used + i];
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        int n_prior;
        n_prior = expected_q.size();
        if (st == ST_DISCARD) begin
            if (b != BYTE_LF) len_cur = 1;
            else begin
                if (len_cur == 0) st = ST_AWAIT;
                len_cur = 0;
            end
            return;
        end
        if (st == ST_AWAIT) carry_n = 0;
        if (b != BYTE_LF) begin
            if (carry_n + len_cur >= LINE_CHARS) begin
                push_error(ERR_TOO_LONG);
                len_cur = 1;
            end else begin
                store[carry_n + len_cur] = b;
                len_cur++;
            end
        end else begin
            if (st == ST_AWAIT) begin
                if (len_cur != 0) decode_time();
            end else begin
                decode_data();
            end
            len_cur = 0;
        end
        if (expected_q.size() > n_prior) expected_q[$].last = 1'b1;
    endfunction

    function automatic bit idle_now();
        return idle_en && ($urandom_range(99) < 35);
    endfunction

    task automatic send_byte(logic [7:0] b);
        while (idle_now()) begin
            byte_ch.valid <= 1'b0;
            byte_ch.rx_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        predict_byte(b);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        byte_ch.valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        // a line end with no result may still be decoding
        repeat (1200) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_INTENSITY_MODE) mode_six = val[0];
        else limit_rd = val;
    endtask

    function automatic logic [7:0] csum_char(logic [7:0] q[$]);
        int unsigned s;
        s = 0;
        foreach (q[i]) s += q[i];
        return 8'((s & 63) + 8'h30);
    endfunction

    function automatic logic [7:0] enc(logic [5:0] v);
        return 8'(v + 8'h30);
    endfunction

    task automatic send_line(logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i]);
        send_byte(BYTE_LF);
    endtask

    task automatic send_time(logic [23:0] t, bit corrupt);
        logic [7:0] q[$];
        q = {enc(t[23:18]), enc(t[17:12]), enc(t[11:6]), enc(t[5:0])};
        q = {q, 8'(csum_char(q) ^ (corrupt ? 8'h01 : 8'h00))};
        send_line(q);
    endtask

    // data line with random byte content (any byte value when wild) and a correct or broken checksum
    task automatic send_data(int n, bit corrupt, bit wild);
        logic [7:0] q[$];
        for (int i = 0; i < n; i++)
            q = {q, (wild ? 8'($urandom) : 8'($urandom_range(8'h30, 8'h6F)))};
        q = {q, 8'(csum_char(q) ^ (corrupt ? 8'h04 : 8'h00))};
        send_line(q);
    endtask

    task automatic test_directed();
        logic [7:0] q[$];
        send_byte(BYTE_LF);                     // empty line before timestamp
        send_line({8'h30, 8'h30, 8'h31});       // short timestamp line
        send_byte(BYTE_LF);
        send_time(24'hFFFFFF, 1'b1);            // bad time checksum
        send_byte(BYTE_LF);
        send_time(24'hFFFFFF, 1'b0);
        send_data(9, 1'b0, 1'b0);
        send_data(4, 1'b0, 1'b0);               // group split across lines
        q = {8'h00, 8'hFF, 8'h30, 8'h6F, 8'h80, 8'h2F};
        q = {q, csum_char(q)};
        send_line(q);
        send_data(5, 1'b1, 1'b0);               // data checksum failure
        send_byte(BYTE_LF);
        send_time(24'h000000, 1'b0);            // wrap
        send_byte(BYTE_LF);                     // scan end
        send_time(24'h000000, 1'b0);
        send_time(24'h000000, 1'b0);            // sent in the data phase, so decoded as a data line, not as a repeat
        send_byte(BYTE_LF);
        wait_drained();
    endtask

    task automatic test_limits();
        write_cfg(CFG_MAX_READINGS, 12'd1);
        write_cfg(CFG_INTENSITY_MODE, 1'b1);
        send_time(24'h000100, 1'b0);
        send_data(12, 1'b0, 1'b1);              // too many readings
        send_byte(BYTE_LF);
        send_time(24'h000200, 1'b0);
        for (int i = 0; i < 80; i++) send_byte(8'h41);   // line too long
        send_byte(BYTE_LF);
        send_byte(BYTE_LF);
        wait_drained();
    endtask

    task automatic random_scan();
        int nl;
        logic [23:0] t;
        t = $urandom_range(3) == 0 ? prev_t[23:0] : 24'($urandom);
        send_time(t, $urandom_range(15) == 0);
        nl = $urandom_range(1, 4);
        for (int l = 0; l < nl; l++)
            send_data($urandom_range(0, 14), $urandom_range(19) == 0,
                      $urandom_range(3) == 0);
        send_byte(BYTE_LF);
        if (st == ST_DISCARD) send_byte(BYTE_LF);
        if ($urandom_range(9) == 0) send_byte(8'($urandom));  // noise
    endtask

    task automatic test_random(int target);
        int start;
        start = n_bytes;
        while (n_bytes - start < target) random_scan();
        send_byte(BYTE_LF);
        send_byte(BYTE_LF);
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (600) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                send_time(24'h123456, 1'b0);
                send_data(30, 1'b0, 1'b0);
                send_data(30, 1'b0, 1'b0);
                send_byte(BYTE_LF);
            end
        join
        wait_drained();
    endtask

    // result receiver
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= !rx_hold && !idle_now();
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected result kind=%0d", res_ch.result_kind);
                errors++;
            end else begin
                t_result x;
                x = expected_q.pop_front();
                case (x.kind)
                    KIND_READING: n_readings++;
                    KIND_TIME:    n_timestamps++;
                    KIND_ERROR:   n_errors_seen++;
                    default: ;
                endcase
                if (res_ch.result_kind !== x.kind) begin
                    $error("result_kind expected %0d got %0d", x.kind, res_ch.result_kind);
                    errors++;
                end
                if (res_ch.range_mm !== x.range_mm) begin
                    $error("range_mm expected %0d got %0d", x.range_mm, res_ch.range_mm);
                    errors++;
                end
                if (res_ch.intensity !== x.intensity) begin
                    $error("intensity expected %0d got %0d", x.intensity, res_ch.intensity);
                    errors++;
                end
                if (res_ch.time_ms !== x.time_ms) begin
                    $error("time_ms expected %0h got %0h", x.time_ms, res_ch.time_ms);
                    errors++;
                end
                if (res_ch.error_code !== x.err) begin
                    $error("error_code expected %0d got %0d", x.err, res_ch.error_code);
                    errors++;
                end
                if (res_ch.last !== x.last) begin
                    $error("last expected %0d got %0d", x.last, res_ch.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

    initial begin
        mode_six = 1'b0; limit_rd = MAX_READINGS_RESET; st = ST_AWAIT;
        len_cur = 0; carry_n = 0; rd_count = 0; prev_t = 0; wraps = 0; reps = 0;
        foreach (store[i]) store[i] = 8'h00;
        byte_ch.valid = 1'b0;
        byte_ch.rx_byte = 8'h00;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_limits();
        test_backpressure();
        write_cfg(CFG_MAX_READINGS, 12'd4095);
        write_cfg(CFG_INTENSITY_MODE, 1'b0);
        test_random(60);
        write_cfg(CFG_MAX_READINGS, 12'd5);
        write_cfg(CFG_INTENSITY_MODE, 1'b1);
        test_random(40);
        idle_en = 1'b0;                         // no idling on either side
        write_cfg(CFG_MAX_READINGS, 12'd2048);
        test_random(40);
        idle_en = 1'b1;

        $display("covered %0d bytes, %0d results: %0d readings, %0d timestamps, %0d errors",
                 n_bytes, n_results, n_readings, n_timestamps, n_errors_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/sdld_pkg.sv
hdl/sdld_if.sv
hdl/sdld_ram.sv
hdl/sdld_ctrl.sv
hdl/sdld_dp.sv
hdl/scan_data_line_decoder.sv
test/scan_data_line_decoder_tb.sv
